FILE: rtl/core/dsu_pkg.sv
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared widths, defaults and types of the deduplicating ascending sorter.
// ----------------------------------------------------------------------------
package dsu_pkg;

  localparam int VAL_W               = 10;  // width of the value fields
  localparam int CNT_W               = 7;   // width of the count field
  localparam int STORE_DEPTH_DEFAULT = 64;
  localparam int VALUE_BITS_DEFAULT  = 10;

  // Result of the shared comparator: operand a against operand b.
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

FILE: rtl/core/dsu_if.sv
// ----------------------------------------------------------------------------
// dsu_in_if / dsu_out_if
// Valid/ready channels carrying the input values and the sorted results.
// ----------------------------------------------------------------------------
interface dsu_in_if import dsu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value;
  logic             final_item;

  modport source (output valid, output value, output final_item, input ready);
  modport sink   (input valid, input value, input final_item, output ready);
endinterface

interface dsu_out_if import dsu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] sorted_value;
  logic [CNT_W-1:0] unique_count;
  logic             is_last;
  logic             set_empty;
  logic             overflowed;

  modport source (output valid, output sorted_value, output unique_count,
                  output is_last, output set_empty, output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input unique_count,
                  input is_last, input set_empty, input overflowed, output ready);
endinterface

FILE: rtl/core/dsu_cmp.sv
// ----------------------------------------------------------------------------
// dsu_cmp
// Shared magnitude comparator used for both the duplicate check and the
// search for the insertion point.
// ----------------------------------------------------------------------------
module dsu_cmp import dsu_pkg::*; #(
  parameter int W = VALUE_BITS_DEFAULT
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output cmp_res_t     res
);

  assign res.lt = (a < b);
  assign res.eq = (a == b);

endmodule

FILE: rtl/core/dsu_store.sv
// ----------------------------------------------------------------------------
// dsu_store
// Single-write, single-read value store with a registered read port.
// ----------------------------------------------------------------------------
module dsu_store import dsu_pkg::*; #(
  parameter int DEPTH = STORE_DEPTH_DEFAULT,
  parameter int W     = VALUE_BITS_DEFAULT,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/dedup_sort_unique_values.sv
// ----------------------------------------------------------------------------
// dedup_sort_unique_values
// Collects a set of values, drops duplicates and zeros, and returns the
// distinct values in ascending order once the final item has arrived.
//
// in_chan carries one value per request with final_item on the last one of
// the set. out_chan returns one result per distinct value, ascending, each
// with the distinct count and the overflow flag; is_last marks the final
// one. An empty set gives a single result with set_empty high.
// Values are held sorted in a store with one write and one read port; one
// comparator walks the held list under a small sequencer, so the block
// takes one request at a time and holds in_chan.ready low while it works.
// A zero value is dropped. A nonzero value is compared with the held
// entries; unless it is a duplicate or the store is full, the entries from
// its insertion point upwards are shifted up one place and it is written
// in. Each result is read from the store into the output register and held
// there until taken. After the last result the store is empty again.
// Synchronous reset empties the store and drops any pending result.
// ----------------------------------------------------------------------------
module dedup_sort_unique_values import dsu_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT,
  parameter int VALUE_BITS  = VALUE_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  dsu_in_if.sink    in_chan,
  dsu_out_if.source out_chan
);

  // Only the low bits that fit both the value width and the port are kept.
  localparam int SW = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_SCAN_RD  = 10'b00_0000_0010,
    ST_SCAN_CMP = 10'b00_0000_0100,
    ST_SH_RD    = 10'b00_0000_1000,
    ST_SH_WR    = 10'b00_0001_0000,
    ST_INS      = 10'b00_0010_0000,
    ST_FINISH   = 10'b00_0100_0000,
    ST_EM_RD    = 10'b00_1000_0000,
    ST_EM_LD    = 10'b01_0000_0000,
    ST_EM_WAIT  = 10'b10_0000_0000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] sh_r, sh_nxt;
  logic          ovf_r, ovf_nxt;
  logic          fin_r, fin_nxt;
  logic [SW-1:0] v_r, v_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [SW-1:0] o_val_r, o_val_nxt;
  logic [CW-1:0] o_cnt_r, o_cnt_nxt;
  logic          o_last_r, o_last_nxt;
  logic          o_empty_r, o_empty_nxt;
  logic          o_ovf_r, o_ovf_nxt;

  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [SW-1:0] st_wdata;
  logic [AW-1:0] st_raddr;
  logic [SW-1:0] st_rdata;
  cmp_res_t      cmp;
  logic [CW-1:0] sh_dec;

  dsu_store #(.DEPTH(STORE_DEPTH), .W(SW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  dsu_cmp #(.W(SW)) u_cmp (
    .a   (v_r),
    .b   (st_rdata),
    .res (cmp)
  );

  assign sh_dec = sh_r - CW'(1);

  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.sorted_value = VAL_W'(o_val_r);
  assign out_chan.unique_count = CNT_W'(o_cnt_r);
  assign out_chan.is_last      = o_last_r;
  assign out_chan.set_empty    = o_empty_r;
  assign out_chan.overflowed   = o_ovf_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    sh_nxt        = sh_r;
    ovf_nxt       = ovf_r;
    fin_nxt       = fin_r;
    v_nxt         = v_r;
    out_valid_nxt = out_valid_r;
    o_val_nxt     = o_val_r;
    o_cnt_nxt     = o_cnt_r;
    o_last_nxt    = o_last_r;
    o_empty_nxt   = o_empty_r;
    o_ovf_nxt     = o_ovf_r;
    st_we         = 1'b0;
    st_waddr      = idx_r[AW-1:0];
    st_wdata      = v_r;
    st_raddr      = idx_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          v_nxt   = in_chan.value[SW-1:0];
          fin_nxt = in_chan.final_item;
          idx_nxt = '0;
          if (in_chan.value[SW-1:0] == '0) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        if (idx_r == count_r) begin
          // Larger than everything held: append, unless the store is full.
          if (count_r == CW'(STORE_DEPTH)) begin
            ovf_nxt   = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            sh_nxt    = count_r;
            state_nxt = ST_SH_RD;
          end
        end else begin
          state_nxt = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        priority if (cmp.eq) begin
          state_nxt = ST_FINISH;
        end else if (cmp.lt) begin
          if (count_r == CW'(STORE_DEPTH)) begin
            ovf_nxt   = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            sh_nxt    = count_r;
            state_nxt = ST_SH_RD;
          end
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SH_RD: begin
        // Entries from the insertion point upwards move one place up.
        st_raddr = sh_dec[AW-1:0];
        if (sh_r == idx_r) begin
          state_nxt = ST_INS;
        end else begin
          state_nxt = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        st_we     = 1'b1;
        st_waddr  = sh_r[AW-1:0];
        st_wdata  = st_rdata;
        sh_nxt    = sh_dec;
        state_nxt = ST_SH_RD;
      end
      ST_INS: begin
        st_we     = 1'b1;
        count_nxt = count_r + CW'(1);
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        idx_nxt = '0;
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (count_r == '0) begin
          o_val_nxt     = '0;
          o_cnt_nxt     = '0;
          o_last_nxt    = 1'b1;
          o_empty_nxt   = 1'b1;
          o_ovf_nxt     = ovf_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_EM_WAIT;
        end else begin
          state_nxt = ST_EM_RD;
        end
      end
      ST_EM_RD: begin
        state_nxt = ST_EM_LD;
      end
      ST_EM_LD: begin
        o_val_nxt     = st_rdata;
        o_cnt_nxt     = count_r;
        o_last_nxt    = ((idx_r + CW'(1)) == count_r);
        o_empty_nxt   = 1'b0;
        o_ovf_nxt     = ovf_r;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_EM_WAIT;
      end
      ST_EM_WAIT: begin
        if (out_chan.ready) begin
          out_valid_nxt = 1'b0;
          if (o_last_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = ST_EM_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      sh_r        <= '0;
      ovf_r       <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      sh_r        <= sh_nxt;
      ovf_r       <= ovf_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r       <= v_nxt;
    o_val_r   <= o_val_nxt;
    o_cnt_r   <= o_cnt_nxt;
    o_last_r  <= o_last_nxt;
    o_empty_r <= o_empty_nxt;
    o_ovf_r   <= o_ovf_nxt;
  end

endmodule
